// ===== rtl/lkvc_pkg.sv =====
// lkvc_pkg: shared constants and codes for the lru key-value cache
// no dependencies; imported by lkvc_cell and lru_key_value_cache
package lkvc_pkg;

    // default number of built entries
    localparam int LKVC_ENTRIES = 16;

    // field widths fixed by the interface
    localparam int CAP_W = 5;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    // capacity register after reset
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // request kinds carried on tuser
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // update kinds broadcast to the cell row
    localparam logic UPD_PROMOTE = 1'b0;
    localparam logic UPD_FILL    = 1'b1;

    // read value returned on a get miss
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

endpackage

// ===== rtl/lkvc_cell.sv =====
// lkvc_cell: one entry of the cache (key, value, valid, recency rank)
// checks the search token passing through and applies the update broadcast
// depends on lkvc_pkg; token and update types come from the top level
module lkvc_cell
    import lkvc_pkg::*;
#(
    parameter int  ENTRIES = LKVC_ENTRIES,
    parameter int  IDX     = 0,
    parameter type tok_t   = logic,
    parameter type upd_t   = logic
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [KEY_W-1:0] req_key,
    input  tok_t             tok_in,
    output tok_t             tok_out,
    input  upd_t             upd
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AGE_W = IDX_W;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic             valid_reg;
    logic             valid_next;
    logic [AGE_W-1:0] age_reg;
    logic [AGE_W-1:0] age_next;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic             is_target;
    logic             key_match;

    // search: record first match, lowest free slot and oldest valid slot
    always_comb
    begin
        tok_next  = tok_in;
        key_match = valid_reg && (key_reg == req_key);
        if (tok_in.valid)
        begin
            if (!tok_in.found && key_match)
            begin
                tok_next.found       = 1'b1;
                tok_next.found_idx   = MY_IDX;
                tok_next.found_age   = age_reg;
                tok_next.found_value = value_reg;
            end
            if (!tok_in.free_found && !valid_reg)
            begin
                tok_next.free_found = 1'b1;
                tok_next.free_idx   = MY_IDX;
            end
            if (valid_reg && (!tok_in.victim_found || (age_reg > tok_in.victim_age)))
            begin
                tok_next.victim_found = 1'b1;
                tok_next.victim_idx   = MY_IDX;
                tok_next.victim_age   = age_reg;
            end
        end
    end

    // token register toward the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

    // recency and valid update from the broadcast
    always_comb
    begin
        is_target  = (upd.target == MY_IDX);
        valid_next = valid_reg;
        age_next   = age_reg;
        if (upd.valid)
        begin
            if (is_target)
            begin
                age_next = '0;
                if (upd.op == UPD_FILL)
                begin
                    valid_next = 1'b1;
                end
            end
            else if (valid_reg)
            begin
                if ((upd.op == UPD_FILL) || (age_reg < upd.ref_age))
                begin
                    age_next = age_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
        end
    end

    // key and value storage, written only on the targeted entry
    always_ff @(posedge clk)
    begin
        if (upd.valid && is_target && upd.wr_key)
        begin
            key_reg <= upd.key;
        end
        if (upd.valid && is_target && upd.wr_value)
        begin
            value_reg <= upd.value;
        end
    end

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// lru_key_value_cache: fully associative key-value cache, lru replacement
// top level: request handshake, search token launch, decision and result register
// depends on lkvc_pkg and lkvc_cell
//
// Each request (get or put) is taken when s_axis_tready is high, which is whenever no
// other request is in flight; a finished result may still sit in the output register.
// The request launches a search token that walks the row of ENTRIES cells one cell per
// clock, collecting the matching entry, the lowest free slot and the least recent entry.
// Any update is then broadcast to all cells at once, as soon as the output register is
// free to take the result. A get hit returns the stored value, a get miss returns all
// ones, a put returns zero; hit reports whether the key was present. The capacity
// register (cfg_wr_en / cfg_wr_data) limits the entries in use: zero acts as one and
// values above ENTRIES act as ENTRIES. The user must write it only while no request
// is in flight; the block itself does not enforce this. Entries need no clearing after
// reset.
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = LKVC_ENTRIES
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CAP_W-1:0]       cfg_wr_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [KEY_W+VAL_W-1:0] s_axis_tdata,   // key [31:0], value [63:32]
    input  logic [0:0]             s_axis_tuser,   // cmd [0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [VAL_W-1:0]       m_axis_tdata,   // read_value [31:0]
    output logic [0:0]             m_axis_tuser    // hit [0]
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AGE_W = IDX_W;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    typedef struct packed {
        logic             valid;
        logic             found;
        logic [IDX_W-1:0] found_idx;
        logic [AGE_W-1:0] found_age;
        logic [VAL_W-1:0] found_value;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic             victim_found;
        logic [IDX_W-1:0] victim_idx;
        logic [AGE_W-1:0] victim_age;
    } tok_t;

    typedef struct packed {
        logic             valid;
        logic             op;
        logic [IDX_W-1:0] target;
        logic [AGE_W-1:0] ref_age;
        logic             wr_key;
        logic             wr_value;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } upd_t;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic             launch_reg;
    logic             req_cmd_reg;
    logic [KEY_W-1:0] req_key_reg;
    logic [VAL_W-1:0] req_value_reg;
    logic [CAP_W-1:0] capacity_reg;
    logic [OCC_W-1:0] occupancy_reg;
    tok_t             tok_hold_reg;
    logic             m_valid_reg;
    logic             m_hit_reg;
    logic [VAL_W-1:0] m_value_reg;

    tok_t             tok_chain [ENTRIES+1];
    logic [ENTRIES:0] tok_valid_vec;
    upd_t             upd;
    logic             accept;
    logic             fire;
    logic             want_upd;
    logic             occ_inc;
    logic             res_hit;
    logic [VAL_W-1:0] res_value;
    logic [CAP_W-1:0] cap_eff;
    logic             full;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign fire          = (state_reg == ST_DECIDE) && (!m_valid_reg || m_axis_tready);

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_cmd_reg   <= s_axis_tuser[0];
            req_key_reg   <= s_axis_tdata[KEY_W-1:0];
            req_value_reg <= s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (tok_chain[ENTRIES].valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= accept;
        end
    end

    // search token entering the first cell
    always_comb
    begin
        tok_chain[0]       = '0;
        tok_chain[0].valid = launch_reg;
    end

    // row of entry cells
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lkvc_cell #(
            .ENTRIES (ENTRIES),
            .IDX     (i),
            .tok_t   (tok_t),
            .upd_t   (upd_t)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .req_key (req_key_reg),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i+1]),
            .upd     (upd)
        );
    end

    for (genvar i = 0; i <= ENTRIES; i++)
    begin : g_tok_valid
        assign tok_valid_vec[i] = tok_chain[i].valid;
    end

    // hold the finished search result
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_SEARCH) && tok_chain[ENTRIES].valid)
        begin
            tok_hold_reg <= tok_chain[ENTRIES];
        end
    end

    // fullness against the effective capacity
    always_comb
    begin
        cap_eff = (capacity_reg == '0) ? CAP_W'(1) : capacity_reg;
        full    = (CMP_W'(occupancy_reg) >= CMP_W'(cap_eff))
               || (occupancy_reg >= OCC_W'(ENTRIES));
    end

    // decision: result and update broadcast
    always_comb
    begin
        upd       = '0;
        upd.key   = req_key_reg;
        upd.value = req_value_reg;
        want_upd  = 1'b0;
        occ_inc   = 1'b0;
        res_hit   = tok_hold_reg.found;
        res_value = '0;
        if (req_cmd_reg == CMD_GET)
        begin
            if (tok_hold_reg.found)
            begin
                want_upd    = 1'b1;
                upd.op      = UPD_PROMOTE;
                upd.target  = tok_hold_reg.found_idx;
                upd.ref_age = tok_hold_reg.found_age;
                res_value   = tok_hold_reg.found_value;
            end
            else
            begin
                res_value = MISS_VALUE;
            end
        end
        else if (tok_hold_reg.found)
        begin
            want_upd     = 1'b1;
            upd.op       = UPD_PROMOTE;
            upd.target   = tok_hold_reg.found_idx;
            upd.ref_age  = tok_hold_reg.found_age;
            upd.wr_value = 1'b1;
        end
        else if (full)
        begin
            // evict the least recent entry in place
            want_upd     = tok_hold_reg.victim_found;
            upd.op       = UPD_PROMOTE;
            upd.target   = tok_hold_reg.victim_idx;
            upd.ref_age  = tok_hold_reg.victim_age;
            upd.wr_key   = 1'b1;
            upd.wr_value = 1'b1;
        end
        else
        begin
            // fill the lowest free slot, every valid entry ages
            want_upd     = tok_hold_reg.free_found;
            occ_inc      = tok_hold_reg.free_found;
            upd.op       = UPD_FILL;
            upd.target   = tok_hold_reg.free_idx;
            upd.wr_key   = 1'b1;
            upd.wr_value = 1'b1;
        end
        upd.valid = fire && want_upd;
    end

    // occupancy count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupancy_reg <= '0;
        end
        else if (fire && occ_inc)
        begin
            occupancy_reg <= occupancy_reg + 1'b1;
        end
    end

    // output register, held until the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            m_hit_reg   <= res_hit;
            m_value_reg <= res_value;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_value_reg;
    assign m_axis_tuser[0] = m_hit_reg;

    // at most one search token in the cell row
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valid_vec))
        else $error("more than one search token in the cell row");

    // a transfer in launches exactly one search
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SEARCH) && launch_reg)
        else $error("request transfer did not launch a search");

    // a new result only comes from the decision step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DECIDE))
        else $error("result appeared outside the decision step");

    // occupancy never passes the built entry count
    assert property (@(posedge clk) disable iff (!rst_n)
        occupancy_reg <= OCC_W'(ENTRIES))
        else $error("occupancy above entry count");

endmodule
